// File: rtl/core/tlfq_pkg.sv
// Shared types and constants of the three-level feedback queue scheduler.
package tlfq_pkg;

   localparam int unsigned OpcodeWidth = 3;
   localparam int unsigned IdWidth     = 6;
   localparam int unsigned TickWidth   = 4;
   localparam int unsigned LevelWidth  = 2;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned CsrIdxWidth = 1;

   localparam logic [TickWidth-1:0] TickMax       = 4'd15;
   localparam logic [TickWidth-1:0] OtherQuantum  = 4'd4;

   typedef enum logic [OpcodeWidth-1:0] {
      OP_ADD      = 3'd0,
      OP_SLEEP    = 3'd1,
      OP_WAKE     = 3'd2,
      OP_DISPATCH = 3'd3,
      OP_EXIT     = 3'd4
   } opcode_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   localparam logic [CsrIdxWidth-1:0] CSR_QUANTUM0 = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_QUANTUM1 = 1'd1;

   // One result beat.
   typedef struct packed {
      logic                   grant_valid;
      logic [IdWidth-1:0]     grant_task;
      logic [LevelWidth-1:0]  grant_level;
      logic                   demoted;
      logic [StatusWidth-1:0] status;
   } result_type;

endpackage

// File: rtl/core/tlfq_queue_mem.sv
// Queue entry memory: one write port and one registered read port.
module tlfq_queue_mem #(
   parameter int unsigned DEPTH = 192,
   parameter int unsigned AW    = 8
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [tlfq_pkg::IdWidth-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [tlfq_pkg::IdWidth-1:0] rd_data
);
   import tlfq_pkg::*;

   logic [IdWidth-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/core/three_level_feedback_queue_scheduler.sv
// Top level of the three-level feedback queue scheduler.
// Usage: pulse start with req_opcode and req_task_id while busy is low; the
// beat is taken at that edge and busy stays high until the result is ready.
// One result beat per command appears on the rsp_ ports for one cycle,
// marked by rsp_strobe; the receiver cannot stall it and must take it then.
// The csr_ channel writes the two level quanta (index 0 and 1); writes are
// always ready and should be issued only while busy is low.
// Sleep, unused opcodes, rejected commands and a wake of a runnable task go
// from decode straight to the result; add also pushes the task onto the
// tail of the level 0 queue. Wake and exit scan the task's queue one entry
// at a time and then shift the later entries down; wake also shifts the
// queue up by one to place the task at its head. Dispatch walks the queues
// from the cursor one entry at a time, fetches the granted task's ticks,
// and runs a shift pass when the task leaves its queue. busy falls with the
// result strobe, so the next command can be taken at the edge that ends the
// strobe cycle. Reset empties every queue and clears the presence flags;
// per-task ticks and levels and the queue entries need no clearing, since
// they are written before use.
module three_level_feedback_queue_scheduler #(
   parameter int unsigned MAX_TASKS = 64,
   parameter int unsigned LEVELS    = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tlfq_pkg::OpcodeWidth-1:0]  req_opcode,
   input  logic [tlfq_pkg::IdWidth-1:0]      req_task_id,
   output logic                              rsp_strobe,
   output logic                              rsp_grant_valid,
   output logic [tlfq_pkg::IdWidth-1:0]      rsp_grant_task,
   output logic [tlfq_pkg::LevelWidth-1:0]   rsp_grant_level,
   output logic                              rsp_demoted,
   output logic [tlfq_pkg::StatusWidth-1:0]  rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tlfq_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [tlfq_pkg::TickWidth-1:0]    csr_data
);
   import tlfq_pkg::*;

   localparam int unsigned TW  = $clog2(MAX_TASKS);
   localparam int unsigned LW  = (TW + 1);
   localparam int unsigned LVW = (LEVELS > 2) ? $clog2(LEVELS) : 1;
   localparam int unsigned AW  = $clog2(LEVELS * MAX_TASKS);
   localparam int unsigned RW  = TickWidth + LVW;
   localparam logic [LW-1:0] MaxLen = LW'(MAX_TASKS);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_FIND_RD, S_FIND_CMP, S_SHIFT_RD, S_SHIFT_WR,
      S_HEAD_RD, S_HEAD_WR, S_DISP_RD, S_DISP_CMP, S_DISP_ACT, S_PUSH,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      K_NONE, K_WAKE, K_EXIT, K_MOVE
   } kind_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   logic [TickWidth-1:0]  quantum0_ff, quantum0_in, quantum1_ff, quantum1_in;
   logic [LW-1:0]         qlen_ff [LEVELS];
   logic [LW-1:0]         qlen_in [LEVELS];
   logic [MAX_TASKS-1:0]  runnable_ff, runnable_in, present_ff, present_in;
   logic [LVW-1:0]        cur_lv_ff, cur_lv_in;
   logic [LW-1:0]         cur_idx_ff, cur_idx_in;

   logic [OpcodeWidth-1:0] op_ff, op_in;
   logic [TW-1:0]         id_ff, id_in;
   logic [IdWidth-1:0]    idf_ff, idf_in;  // id as received, for the range check
   logic [LVW-1:0]        lv_ff, lv_in;    // working level
   logic [LW-1:0]         pos_ff, pos_in;  // working position
   logic [LVW-1:0]        dst_ff, dst_in;  // level for the tail push
   logic [2:0]            visit_ff, visit_in;
   result_type            res_ff, res_in;
   result_type            rsp_res_ff, rsp_res_in;
   logic                  strobe_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [IdWidth-1:0]    wr_data, rd_data;

   // Per-task record: level above ticks, one registered read port.
   logic [RW-1:0]         task_mem [MAX_TASKS];
   logic [RW-1:0]         task_rd_ff;
   logic                  task_wr_en;
   logic [TW-1:0]         task_wr_addr, task_rd_addr;
   logic [RW-1:0]         task_wr_data;

   function automatic logic [AW-1:0] addr_of(input logic [LVW-1:0] lv,
                                             input logic [LW-1:0] pos);
      logic [AW+LW-1:0] a;
      a = (AW+LW)'(lv) * (AW+LW)'(MAX_TASKS) + (AW+LW)'(pos);
      return a[AW-1:0];
   endfunction

   tlfq_queue_mem #(.DEPTH(LEVELS * MAX_TASKS), .AW(AW)) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (task_wr_en) begin
         task_mem[task_wr_addr] <= task_wr_data;
      end
      task_rd_ff <= task_mem[task_rd_addr];
   end

   logic [TW-1:0] rd_id;
   logic          rd_id_ok;
   assign rd_id    = TW'(rd_data);
   assign rd_id_ok = (32'(rd_data) < MAX_TASKS);

   logic [TickWidth-1:0] rec_ticks;
   logic [LVW-1:0]       rec_level;
   assign rec_ticks = task_rd_ff[TickWidth-1:0];
   assign rec_level = task_rd_ff[TickWidth +: LVW];

   logic [TickWidth-1:0] quantum;
   always_comb begin
      if (lv_ff == LVW'(0))      quantum = quantum0_ff;
      else if (lv_ff == LVW'(1)) quantum = quantum1_ff;
      else                       quantum = OtherQuantum;
   end

   logic [TickWidth-1:0] tick_inc;
   assign tick_inc = (rec_ticks < TickMax) ? rec_ticks + 4'd1 : TickMax;

   logic [LVW-1:0] next_lv;
   assign next_lv = (32'(lv_ff) + 1 >= LEVELS) ? LVW'(0) : lv_ff + LVW'(1);
   logic           lv_last;
   assign lv_last = (32'(lv_ff) + 1 >= LEVELS);

   // Memory port use, combinational from the sequencer state.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_of(lv_ff, pos_ff);
      wr_data = rd_data;
      rd_addr = addr_of(lv_ff, pos_ff);
      case (state_ff)
         S_SHIFT_RD: rd_addr = addr_of(lv_ff, pos_ff + LW'(1));
         S_SHIFT_WR: wr_en = 1'b1;
         S_HEAD_RD:  rd_addr = addr_of(lv_ff, pos_ff - LW'(1));
         S_HEAD_WR: begin
            wr_en = 1'b1;
            if (pos_ff == '0) wr_data = IdWidth'(id_ff);
         end
         S_PUSH: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(dst_ff, qlen_ff[dst_ff]);
            wr_data = IdWidth'(id_ff);
         end
         default: ;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_grant_valid = rsp_res_ff.grant_valid;
   assign rsp_grant_task  = rsp_res_ff.grant_task;
   assign rsp_grant_level = rsp_res_ff.grant_level;
   assign rsp_demoted     = rsp_res_ff.demoted;
   assign rsp_status      = rsp_res_ff.status;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      quantum0_in  = quantum0_ff;
      quantum1_in  = quantum1_ff;
      qlen_in      = qlen_ff;
      runnable_in  = runnable_ff;
      present_in   = present_ff;
      cur_lv_in    = cur_lv_ff;
      cur_idx_in   = cur_idx_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      idf_in       = idf_ff;
      lv_in        = lv_ff;
      pos_in       = pos_ff;
      dst_in       = dst_ff;
      visit_in     = visit_ff;
      res_in       = res_ff;
      rsp_res_in   = rsp_res_ff;
      strobe_in    = 1'b0;
      task_wr_en   = 1'b0;
      task_wr_addr = id_ff;
      task_wr_data = '0;
      task_rd_addr = id_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_QUANTUM0) quantum0_in = csr_data;
         if (csr_index == CSR_QUANTUM1) quantum1_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            // Fetch the named task's record so that decode can use its level.
            task_rd_addr = TW'(req_task_id);
            if (start) begin
               op_in    = req_opcode;
               id_in    = TW'(req_task_id);
               idf_in   = req_task_id;
               res_in   = '0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            pos_in   = '0;
            kind_in  = K_NONE;
            state_in = S_DONE;
            if (op_ff == OP_DISPATCH) begin
               lv_in    = (32'(cur_lv_ff) < LEVELS) ? cur_lv_ff : LVW'(0);
               pos_in   = cur_idx_ff;
               visit_in = '0;
               state_in = S_DISP_RD;
            end else if (op_ff > OP_EXIT) begin
               state_in = S_DONE;
            end else if (32'(idf_ff) >= MAX_TASKS) begin
               res_in.status = ST_UNKNOWN;
            end else if (op_ff == OP_ADD) begin
               if (present_ff[id_ff] || qlen_ff[0] >= MaxLen) begin
                  res_in.status = ST_FULL;
               end else begin
                  present_in[id_ff]  = 1'b1;
                  runnable_in[id_ff] = 1'b1;
                  task_wr_en   = 1'b1;
                  task_wr_data = '0;
                  dst_in       = '0;
                  state_in     = S_PUSH;
               end
            end else if (!present_ff[id_ff]) begin
               res_in.status = ST_UNKNOWN;
            end else begin
               lv_in = (32'(rec_level) < LEVELS) ? rec_level : LVW'(LEVELS - 1);
               if (op_ff == OP_SLEEP) begin
                  runnable_in[id_ff] = 1'b0;
               end else if (op_ff == OP_WAKE) begin
                  if (!runnable_ff[id_ff]) begin
                     kind_in  = K_WAKE;
                     state_in = S_FIND_RD;
                  end
               end else begin
                  kind_in  = K_EXIT;
                  state_in = S_FIND_RD;
               end
            end
         end
         S_FIND_RD: begin
            if (pos_ff >= qlen_ff[lv_ff]) begin
               // Not in its queue: nothing to remove.
               state_in = (kind_ff == K_WAKE) ? S_HEAD_RD : S_DONE;
               pos_in   = qlen_ff[lv_ff];
               if (kind_ff == K_EXIT) begin
                  present_in[id_ff]  = 1'b0;
                  runnable_in[id_ff] = 1'b0;
               end
            end else begin
               state_in = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (rd_id_ok && rd_id == id_ff) begin
               if (lv_ff == cur_lv_ff && pos_ff < cur_idx_ff)
                  cur_idx_in = cur_idx_ff - LW'(1);
               state_in = S_SHIFT_RD;
            end else begin
               pos_in   = pos_ff + LW'(1);
               state_in = S_FIND_RD;
            end
         end
         S_SHIFT_RD: begin
            if (pos_ff + LW'(1) >= qlen_ff[lv_ff]) begin
               qlen_in[lv_ff] = qlen_ff[lv_ff] - LW'(1);
               case (kind_ff)
                  K_WAKE: begin
                     pos_in   = qlen_ff[lv_ff] - LW'(1);
                     state_in = S_HEAD_RD;
                  end
                  K_EXIT: begin
                     present_in[id_ff]  = 1'b0;
                     runnable_in[id_ff] = 1'b0;
                     state_in = S_DONE;
                  end
                  default: state_in = S_PUSH;
               endcase
            end else begin
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            pos_in   = pos_ff + LW'(1);
            state_in = S_SHIFT_RD;
         end
         S_HEAD_RD: begin
            state_in = S_HEAD_WR;
         end
         S_HEAD_WR: begin
            if (pos_ff == '0) begin
               qlen_in[lv_ff]     = qlen_ff[lv_ff] + LW'(1);
               runnable_in[id_ff] = 1'b1;
               task_wr_en   = 1'b1;
               task_wr_data = {lv_ff, TickWidth'(0)};
               state_in     = S_DONE;
            end else begin
               pos_in   = pos_ff - LW'(1);
               state_in = S_HEAD_RD;
            end
         end
         S_DISP_RD: begin
            if (pos_ff >= qlen_ff[lv_ff]) begin
               if (32'(visit_ff) >= LEVELS) begin
                  cur_lv_in  = '0;
                  cur_idx_in = '0;
                  state_in   = S_DONE;
               end else begin
                  visit_in = visit_ff + 3'd1;
                  lv_in    = next_lv;
                  pos_in   = '0;
               end
            end else begin
               state_in = S_DISP_CMP;
            end
         end
         S_DISP_CMP: begin
            if (rd_id_ok && runnable_ff[rd_id]) begin
               id_in        = rd_id;
               task_rd_addr = rd_id;
               state_in     = S_DISP_ACT;
            end else begin
               pos_in   = pos_ff + LW'(1);
               state_in = S_DISP_RD;
            end
         end
         S_DISP_ACT: begin
            res_in.grant_valid = 1'b1;
            res_in.grant_task  = IdWidth'(id_ff);
            res_in.grant_level = LevelWidth'(lv_ff);
            kind_in    = K_MOVE;
            task_wr_en = 1'b1;
            if (lv_last) begin
               // Rotation ends with the cursor back at the top level.
               dst_in       = lv_ff;
               cur_lv_in    = '0;
               cur_idx_in   = '0;
               task_wr_data = {lv_ff, tick_inc};
               state_in     = S_SHIFT_RD;
            end else if (tick_inc >= quantum && qlen_ff[next_lv] < MaxLen) begin
               dst_in         = next_lv;
               cur_lv_in      = lv_ff;
               cur_idx_in     = pos_ff;
               task_wr_data   = {next_lv, TickWidth'(0)};
               res_in.demoted = 1'b1;
               state_in       = S_SHIFT_RD;
            end else begin
               cur_lv_in    = lv_ff;
               cur_idx_in   = pos_ff + LW'(1);
               task_wr_data = {lv_ff, tick_inc};
               state_in     = S_DONE;
            end
         end
         S_PUSH: begin
            qlen_in[dst_ff] = qlen_ff[dst_ff] + LW'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            strobe_in  = 1'b1;
            rsp_res_in = res_ff;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         kind_ff     <= K_NONE;
         quantum0_ff <= 4'd4;
         quantum1_ff <= 4'd4;
         runnable_ff <= '0;
         present_ff  <= '0;
         cur_lv_ff   <= '0;
         cur_idx_ff  <= '0;
         for (int l = 0; l < LEVELS; l++) qlen_ff[l] <= '0;
         rsp_strobe  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         kind_ff     <= kind_in;
         quantum0_ff <= quantum0_in;
         quantum1_ff <= quantum1_in;
         runnable_ff <= runnable_in;
         present_ff  <= present_in;
         cur_lv_ff   <= cur_lv_in;
         cur_idx_ff  <= cur_idx_in;
         for (int l = 0; l < LEVELS; l++) qlen_ff[l] <= qlen_in[l];
         rsp_strobe  <= strobe_in;
      end
      op_ff      <= op_in;
      id_ff      <= id_in;
      idf_ff     <= idf_in;
      lv_ff      <= lv_in;
      pos_ff     <= pos_in;
      dst_ff     <= dst_in;
      visit_ff   <= visit_in;
      res_ff     <= res_in;
      rsp_res_ff <= rsp_res_in;
   end

`ifndef NO_ASSERTIONS
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while still busy");
   a_grant_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_grant_valid) |-> (rsp_grant_task == '0 && !rsp_demoted))
      else $error("grant fields set without a grant");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      qlen_ff[0] <= MaxLen)
      else $error("level 0 queue length beyond capacity");
`endif

endmodule

// File: tb/three_level_feedback_queue_scheduler_tb.sv
// Self-checking testbench for the three-level feedback queue scheduler.
module three_level_feedback_queue_scheduler_tb;
   import tlfq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumTasks  = 64;
   localparam int NumLevels = 3;
   localparam int StallLimit = 5000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [OpcodeWidth-1:0] req_opcode = '0;
   logic [IdWidth-1:0]     req_task_id = '0;
   logic                   rsp_strobe;
   logic                   rsp_grant_valid;
   logic [IdWidth-1:0]     rsp_grant_task;
   logic [LevelWidth-1:0]  rsp_grant_level;
   logic                   rsp_demoted;
   logic [StatusWidth-1:0] rsp_status;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [TickWidth-1:0]   csr_data = '0;

   three_level_feedback_queue_scheduler u_top (
      .clock, .reset, .start, .busy, .req_opcode, .req_task_id,
      .rsp_strobe, .rsp_grant_valid, .rsp_grant_task, .rsp_grant_level,
      .rsp_demoted, .rsp_status, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #6 clock = ~clock;

   // Scheduler state as predicted by the testbench.
   logic [IdWidth-1:0]   sched_queue [NumLevels][NumTasks];
   int                   sched_len [NumLevels];
   logic [TickWidth-1:0] sched_ticks [NumTasks];
   int                   sched_level [NumTasks];
   bit                   sched_runnable [NumTasks];
   bit                   sched_present [NumTasks];
   int                   sweep_level;
   int                   sweep_index;
   logic [TickWidth-1:0] quantum0;
   logic [TickWidth-1:0] quantum1;

   result_type pending_results[$];
   int         mismatch_count = 0;
   int         idle_pct = 0;

   function automatic int find_entry(int lv, int id);
      for (int i = 0; i < sched_len[lv]; i++) begin
         if (sched_queue[lv][i] == id) return i;
      end
      return NumTasks;
   endfunction

   function automatic void drop_entry(int lv, int pos);
      if (pos >= sched_len[lv]) return;
      for (int i = pos; i < sched_len[lv] - 1; i++) sched_queue[lv][i] = sched_queue[lv][i+1];
      sched_len[lv]--;
      // Keep the sweep from skipping the entry that slid into place.
      if (lv == sweep_level && pos < sweep_index) sweep_index--;
   endfunction

   function automatic void append_entry(int lv, int id);
      if (sched_len[lv] >= NumTasks) return;
      sched_queue[lv][sched_len[lv]] = IdWidth'(id);
      sched_len[lv]++;
   endfunction

   function automatic void prepend_entry(int lv, int id);
      if (sched_len[lv] >= NumTasks) return;
      for (int i = sched_len[lv]; i > 0; i--) sched_queue[lv][i] = sched_queue[lv][i-1];
      sched_queue[lv][0] = IdWidth'(id);
      sched_len[lv]++;
   endfunction

   function automatic int quantum_for(int lv);
      if (lv == 0) return quantum0;
      if (lv == 1) return quantum1;
      return OtherQuantum;
   endfunction

   function automatic result_type pick_next_task();
      result_type r;
      int lv;
      int idx;
      int id;
      int t;
      r = '0;
      lv = (sweep_level < NumLevels) ? sweep_level : 0;
      idx = sweep_index;
      for (int v = 0; v <= NumLevels; v++) begin
         for (int i = idx; i < sched_len[lv]; i++) begin
            id = sched_queue[lv][i];
            if (!sched_runnable[id]) continue;
            t = sched_ticks[id];
            if (t < TickMax) t++;
            sched_ticks[id] = TickWidth'(t);
            r.grant_valid = 1'b1;
            r.grant_task  = IdWidth'(id);
            r.grant_level = LevelWidth'(lv);
            sweep_level = lv;
            sweep_index = i;
            if (lv + 1 < NumLevels) begin
               if (t >= quantum_for(lv) && sched_len[lv+1] < NumTasks) begin
                  drop_entry(lv, i);
                  append_entry(lv + 1, id);
                  sched_level[id] = lv + 1;
                  sched_ticks[id] = '0;
                  r.demoted = 1'b1;
               end else begin
                  sweep_index = i + 1;
               end
            end else begin
               drop_entry(lv, i);
               append_entry(lv, id);
               sweep_level = 0;
               sweep_index = 0;
            end
            return r;
         end
         lv = (lv + 1) % NumLevels;
         idx = 0;
      end
      sweep_level = 0;
      sweep_index = 0;
      return r;
   endfunction

   function automatic result_type schedule_command(logic [OpcodeWidth-1:0] op, int id);
      result_type r;
      int lv;
      r = '0;
      if (op == OP_DISPATCH) return pick_next_task();
      if (op > OP_EXIT) return r;
      if (op == OP_ADD) begin
         if (sched_present[id] || sched_len[0] >= NumTasks) begin
            r.status = ST_FULL;
            return r;
         end
         sched_present[id] = 1'b1;
         sched_runnable[id] = 1'b1;
         sched_level[id] = 0;
         sched_ticks[id] = '0;
         append_entry(0, id);
         return r;
      end
      if (!sched_present[id]) begin
         r.status = ST_UNKNOWN;
         return r;
      end
      lv = sched_level[id];
      if (op == OP_SLEEP) begin
         sched_runnable[id] = 1'b0;
      end else if (op == OP_WAKE) begin
         if (!sched_runnable[id]) begin
            drop_entry(lv, find_entry(lv, id));
            prepend_entry(lv, id);
            sched_ticks[id] = '0;
            sched_runnable[id] = 1'b1;
         end
      end else begin
         drop_entry(lv, find_entry(lv, id));
         sched_present[id] = 1'b0;
         sched_runnable[id] = 1'b0;
         sched_ticks[id] = '0;
         sched_level[id] = 0;
      end
      return r;
   endfunction

   task automatic send_command(logic [OpcodeWidth-1:0] op, logic [IdWidth-1:0] id);
      @(posedge clock);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_task_id <= id;
      do @(posedge clock); while (busy);
      pending_results.push_back(schedule_command(op, id));
      start <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_quantum(logic [CsrIdxWidth-1:0] idx, logic [TickWidth-1:0] value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_QUANTUM0) quantum0 = value;
      else quantum1 = value;
   endtask

   task automatic report_field(string name, int expected, int actual);
      if (expected != actual) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Mismatch on %s: expected %0d, got %0d", name, expected, actual);
      end
   endtask

   // Results cannot be held off, so each strobe is checked at the edge that takes it.
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result beat");
         end else begin
            exp_r = pending_results.pop_front();
            report_field("grant_valid", exp_r.grant_valid, rsp_grant_valid);
            report_field("grant_task", exp_r.grant_task, rsp_grant_task);
            report_field("grant_level", exp_r.grant_level, rsp_grant_level);
            report_field("demoted", exp_r.demoted, rsp_demoted);
            report_field("status", exp_r.status, rsp_status);
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_directed();
      send_command(OP_DISPATCH, 6'd0);
      send_command(OP_ADD, 6'd0);
      send_command(OP_ADD, 6'd63);
      send_command(OP_ADD, 6'd0);
      send_command(OP_SLEEP, 6'd21);
      send_command(OP_WAKE, 6'd42);
      send_command(OP_EXIT, 6'd42);
      repeat (5) send_command(OP_DISPATCH, 6'd0);
      send_command(OP_SLEEP, 6'd63);
      send_command(OP_SLEEP, 6'd63);
      send_command(OP_DISPATCH, 6'd0);
      send_command(OP_WAKE, 6'd63);
      send_command(OP_WAKE, 6'd63);
      send_command(OP_DISPATCH, 6'd0);
      send_command(3'd5, 6'd7);
      send_command(3'd6, 6'd63);
      send_command(3'd7, 6'd0);
      send_command(OP_EXIT, 6'd0);
      send_command(OP_EXIT, 6'd63);
      send_command(OP_DISPATCH, 6'd0);
   endtask

   // Every task present at once gives the longest queues and sweeps.
   task automatic test_full_table();
      for (int i = 0; i < NumTasks; i++) send_command(OP_ADD, IdWidth'(i));
      send_command(OP_ADD, 6'd17);
      repeat (30) send_command(OP_DISPATCH, 6'd0);
      for (int i = 0; i < NumTasks; i += 3) send_command(OP_EXIT, IdWidth'(i));
   endtask

   task automatic test_random_mix(int count);
      int pick;
      logic [IdWidth-1:0] id;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         id = ($urandom_range(9) == 0) ? IdWidth'($urandom_range(63))
                                       : IdWidth'($urandom_range(11));
         if (pick < 42) send_command(OP_DISPATCH, IdWidth'($urandom_range(63)));
         else if (pick < 60) send_command(OP_ADD, id);
         else if (pick < 72) send_command(OP_SLEEP, id);
         else if (pick < 84) send_command(OP_WAKE, id);
         else if (pick < 95) send_command(OP_EXIT, id);
         else send_command(OpcodeWidth'($urandom_range(7, 5)), id);
      end
   endtask

   initial begin
      for (int i = 0; i < NumTasks; i++) begin
         sched_ticks[i] = '0;
         sched_level[i] = 0;
         sched_runnable[i] = 1'b0;
         sched_present[i] = 1'b0;
      end
      for (int l = 0; l < NumLevels; l++) sched_len[l] = 0;
      sweep_level = 0;
      sweep_index = 0;
      quantum0 = 4'd4;
      quantum1 = 4'd4;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      write_quantum(CSR_QUANTUM0, 4'd1);
      write_quantum(CSR_QUANTUM1, 4'd15);
      test_full_table();
      test_random_mix(110);
      idle_pct = 65;
      write_quantum(CSR_QUANTUM0, 4'd15);
      write_quantum(CSR_QUANTUM1, 4'd1);
      test_random_mix(110);
      idle_pct = 0;
      write_quantum(CSR_QUANTUM0, 4'd2);
      write_quantum(CSR_QUANTUM1, 4'd3);
      test_random_mix(110);
      idle_pct = 16;
      write_quantum(CSR_QUANTUM0, TickWidth'($urandom_range(15, 1)));
      write_quantum(CSR_QUANTUM1, TickWidth'($urandom_range(15, 1)));
      test_random_mix(110);

      wait_for_results();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/tlfq_pkg.sv
rtl/core/tlfq_queue_mem.sv
rtl/core/three_level_feedback_queue_scheduler.sv
tb/three_level_feedback_queue_scheduler_tb.sv
